// ----- sv/hsl_to_rgb_converter_assert.svh -----
// Assertion macros for the HSL to RGB converter.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define HSL_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define HSL_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/hsl_pkg.sv -----
// Shared types, constants and helpers for the HSL to RGB converter.
package hsl_pkg;

    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam logic [8:0] HALF_TURN  = 9'd256;

    // Sextant codes: dominant channel first, second-component channel second
    localparam logic [2:0] SEXT_R_G = 3'd0;
    localparam logic [2:0] SEXT_G_R = 3'd1;
    localparam logic [2:0] SEXT_G_B = 3'd2;
    localparam logic [2:0] SEXT_B_G = 3'd3;
    localparam logic [2:0] SEXT_B_R = 3'd4;
    localparam logic [2:0] SEXT_R_B = 3'd5;

    typedef struct packed {
        logic [7:0] chroma;
        logic [7:0] light;
        logic [2:0] sextant;
        logic [8:0] weight;
    } chroma_beat_t;

    function automatic logic [7:0] clamp_channel(input logic signed [9:0] v);
        logic [7:0] r;
        if (v[9])
            r = 8'd0;
        else if (v[8])
            r = FULL_SCALE;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

// ----- sv/hsl_pixel_if.sv -----
// Input channel: one HSL pixel per beat.
interface hsl_pixel_if;
    logic        valid;
    logic        ready;
    logic [10:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

// ----- sv/rgb_pixel_if.sv -----
// Output channel: one RGB pixel per beat.
interface rgb_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- sv/hsl_chroma_pipe.sv -----
// Chroma pipeline: span and hue weight, span x saturation, divide by 255 in two steps.
module hsl_chroma_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    hsl_pixel_if.sink             pixel,
    output hsl_pkg::chroma_beat_t mid,
    output logic                  mid_valid,
    input  logic                  mid_ready
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    // stage 1 payload
    logic [7:0] s1_span_reg, s1_sat_reg, s1_light_reg;
    logic [2:0] s1_sext_reg;
    logic [8:0] s1_weight_reg;
    // stage 2 payload
    logic [15:0] s2_prod_reg;
    logic [7:0]  s2_light_reg;
    logic [2:0]  s2_sext_reg;
    logic [8:0]  s2_weight_reg;
    // stage 3 payload
    logic [15:0] s3_prod_reg;
    logic [8:0]  s3_quot_reg;
    logic [7:0]  s3_light_reg;
    logic [2:0]  s3_sext_reg;
    logic [8:0]  s3_weight_reg;
    // stage 4 payload
    hsl_pkg::chroma_beat_t s4_beat_reg;

    logic signed [9:0] dist_raw, phase_raw;
    logic [7:0]  dist_abs;
    logic [8:0]  phase_abs;
    logic [7:0]  span_next;
    logic [8:0]  weight_next;
    logic [15:0] prod_next;
    logic [16:0] quot_sum;
    logic [8:0]  quot_next;
    logic [16:0] quot_x255;
    logic [16:0] rem;
    logic [8:0]  chroma_wide;
    hsl_pkg::chroma_beat_t beat_next;

    assign en4 = !s4_valid_reg || mid_ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign pixel.ready = en1;

    // stage 1: |2l-255| and |(h mod 512)-256|
    always_comb
    begin
        dist_raw    = $signed({1'b0, pixel.lightness, 1'b0}) - $signed(10'd255);
        dist_abs    = dist_raw[9] ? 8'(-dist_raw) : dist_raw[7:0];
        span_next   = hsl_pkg::FULL_SCALE - dist_abs;
        phase_raw   = $signed({1'b0, pixel.hue[8:0]}) - $signed({1'b0, hsl_pkg::HALF_TURN});
        phase_abs   = phase_raw[9] ? 9'(-phase_raw) : phase_raw[8:0];
        weight_next = hsl_pkg::HALF_TURN - phase_abs;
    end

    // stage 2: span x saturation
    assign prod_next = s1_span_reg * s1_sat_reg;

    // stage 3: quotient estimate, low by at most one
    assign quot_sum  = {1'b0, s2_prod_reg} + {9'd0, s2_prod_reg[15:8]};
    assign quot_next = quot_sum[16:8];

    // stage 4: remainder correction
    always_comb
    begin
        quot_x255   = {s3_quot_reg, 8'd0} - {8'd0, s3_quot_reg};
        rem         = {1'b0, s3_prod_reg} - quot_x255;
        chroma_wide = (rem >= 17'd255) ? s3_quot_reg + 9'd1 : s3_quot_reg;
        beat_next.chroma  = chroma_wide[7:0];
        beat_next.light   = s3_light_reg;
        beat_next.sextant = s3_sext_reg;
        beat_next.weight  = s3_weight_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= pixel.valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_span_reg   <= span_next;
            s1_sat_reg    <= pixel.saturation;
            s1_light_reg  <= pixel.lightness;
            s1_sext_reg   <= pixel.hue[10:8];
            s1_weight_reg <= weight_next;
        end
        if (en2)
        begin
            s2_prod_reg   <= prod_next;
            s2_light_reg  <= s1_light_reg;
            s2_sext_reg   <= s1_sext_reg;
            s2_weight_reg <= s1_weight_reg;
        end
        if (en3)
        begin
            s3_prod_reg   <= s2_prod_reg;
            s3_quot_reg   <= quot_next;
            s3_light_reg  <= s2_light_reg;
            s3_sext_reg   <= s2_sext_reg;
            s3_weight_reg <= s2_weight_reg;
        end
        if (en4)
            s4_beat_reg <= beat_next;
    end

    assign mid       = s4_beat_reg;
    assign mid_valid = s4_valid_reg;

endmodule

// ----- sv/hsl_mix_pipe.sv -----
// Mix pipeline: second component and offset, then sextant ordering and clamping.
module hsl_mix_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hsl_pkg::chroma_beat_t mid,
    input  logic                  mid_valid,
    output logic                  mid_ready,
    rgb_pixel_if.source           rgb
);

    logic s5_valid_reg, s6_valid_reg;
    logic en5, en6;

    logic [7:0]        s5_chroma_reg, s5_second_reg;
    logic signed [9:0] s5_offset_reg;
    logic [2:0]        s5_sext_reg;
    logic [7:0]        s6_red_reg, s6_green_reg, s6_blue_reg;

    logic [16:0]       second_prod;
    logic signed [9:0] offset_next;
    logic [7:0]        rc, gc, bc;
    logic [7:0]        red_next, green_next, blue_next;

    assign en6       = !s6_valid_reg || rgb.ready;
    assign en5       = !s5_valid_reg || en6;
    assign mid_ready = en5;

    assign second_prod = mid.chroma * mid.weight;
    assign offset_next = $signed({2'b00, mid.light}) - $signed({3'b000, mid.chroma[7:1]});

    always_comb
    begin
        rc = 8'd0;
        gc = 8'd0;
        bc = 8'd0;
        case (s5_sext_reg)
            hsl_pkg::SEXT_R_G: begin rc = s5_chroma_reg; gc = s5_second_reg; end
            hsl_pkg::SEXT_G_R: begin rc = s5_second_reg; gc = s5_chroma_reg; end
            hsl_pkg::SEXT_G_B: begin gc = s5_chroma_reg; bc = s5_second_reg; end
            hsl_pkg::SEXT_B_G: begin gc = s5_second_reg; bc = s5_chroma_reg; end
            hsl_pkg::SEXT_B_R: begin rc = s5_second_reg; bc = s5_chroma_reg; end
            hsl_pkg::SEXT_R_B: begin rc = s5_chroma_reg; bc = s5_second_reg; end
            default:           begin rc = 8'd0; gc = 8'd0; bc = 8'd0; end
        endcase
        red_next   = hsl_pkg::clamp_channel($signed({2'b00, rc}) + s5_offset_reg);
        green_next = hsl_pkg::clamp_channel($signed({2'b00, gc}) + s5_offset_reg);
        blue_next  = hsl_pkg::clamp_channel($signed({2'b00, bc}) + s5_offset_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (en5) s5_valid_reg <= mid_valid;
            if (en6) s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_chroma_reg <= mid.chroma;
            s5_second_reg <= second_prod[15:8];
            s5_offset_reg <= offset_next;
            s5_sext_reg   <= mid.sextant;
        end
        if (en6)
        begin
            s6_red_reg   <= red_next;
            s6_green_reg <= green_next;
            s6_blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = s6_valid_reg;
    assign rgb.red   = s6_red_reg;
    assign rgb.green = s6_green_reg;
    assign rgb.blue  = s6_blue_reg;

endmodule

// ----- sv/hsl_to_rgb_converter.sv -----
// HSL to RGB converter: top level.
//
// pixel (sink): hue (sextant in bits 10..8, fraction in 7..0), saturation and
//   lightness as value/255. A beat moves when valid and ready are both high.
// rgb (source): red, green, blue, 8 bits each, one beat per pixel beat, in order.
// Six register stages: |2l-255| and hue weight, span x saturation, quotient
//   estimate, remainder correction, second component and offset, ordering and
//   clamp.
// Throughput is one pixel per cycle unless rgb stalls; every stage is fully
//   pipelined and the 8x8 and 8x9 multipliers each sit in their own stage.
// Hue in sextants 6 and 7 gives a grey of lightness minus half the chroma.
// Reset clears all stage valid bits; no output beat is pending afterwards.
// When the receiver stalls, the pipeline keeps filling its empty stages and
//   pixel.ready drops only once every stage holds a beat.
module hsl_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    hsl_pixel_if.sink   pixel,
    rgb_pixel_if.source rgb
);

`include "hsl_to_rgb_converter_assert.svh"

    hsl_pkg::chroma_beat_t mid;
    logic                  mid_valid;
    logic                  mid_ready;

    hsl_chroma_pipe u_chroma (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .mid       (mid),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready)
    );

    hsl_mix_pipe u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid       (mid),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .rgb       (rgb)
    );

    `HSL_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !pixel.ready, rgb.valid)
    `HSL_ASSERT_NEXT(a_mid_beat_held, clk, rst_n, mid_valid && !mid_ready, mid_valid)
    `HSL_ASSERT_NOW(a_chroma_range, clk, rst_n, mid_valid, mid.chroma <= 8'd254)

endmodule
